### rtl/blps_pkg.sv
package blps_pkg;

	localparam int LED_W    = 8;
	localparam int MODE_W   = 3;
	localparam int STEP_W   = 3;
	localparam int PERIOD_W = 10;

	localparam logic [LED_W-1:0]    LEDS_ALL_ON   = 8'hff;
	localparam logic [LED_W-1:0]    LEDS_ALL_OFF  = 8'h00;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 10'd200;
	localparam logic [PERIOD_W-1:0] COUNTER_TOP   = 10'd1023;
	localparam logic [STEP_W-1:0]   FLOWER_STEPS  = 3'd4;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALL_ON       = 3'd0,
		MODE_ALL_OFF      = 3'd1,
		MODE_FLOWER_OPEN  = 3'd2,
		MODE_FLOWER_CLOSE = 3'd3,
		MODE_FILL_UP      = 3'd4,
		MODE_FILL_DOWN    = 3'd5,
		MODE_DOT_UP       = 3'd6,
		MODE_DOT_DOWN     = 3'd7
	} mode_t;

	typedef struct packed {
		logic [LED_W-1:0]    leds;
		mode_t               mode;
		logic [STEP_W-1:0]   step;
		logic [PERIOD_W-1:0] ms_cnt;
	} seq_state_t;

	typedef struct packed {
		logic tick;
		logic press;
	} item_t;

endpackage

### rtl/blps_item_if.sv
interface blps_item_if;
	logic valid;
	logic ready;
	logic tick;
	logic press;

	modport source (output valid, output tick, output press, input ready);
	modport sink   (input valid, input tick, input press, output ready);
endinterface

### rtl/blps_result_if.sv
interface blps_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] leds;
	logic [2:0] mode;

	modport source (output valid, output leds, output mode, input ready);
	modport sink   (input valid, input leds, input mode, output ready);
endinterface

### rtl/blps_cfg_if.sv
interface blps_cfg_if;
	logic       valid;
	logic       ready;
	logic [9:0] period_ms;

	modport source (output valid, output period_ms, input ready);
	modport sink   (input valid, input period_ms, output ready);
endinterface

### rtl/blps_step.sv
module blps_step
	import blps_pkg::*;
(
	input  seq_state_t          cur,
	input  item_t               item,
	input  logic [PERIOD_W-1:0] period_ms,
	output seq_state_t          nxt
);

	logic [PERIOD_W-1:0] cnt_inc;
	logic [LED_W-1:0]    leds_stp;
	logic [STEP_W-1:0]   step_stp;
	logic [STEP_W-1:0]   step_inc;
	logic [STEP_W:0]     hi_pos;
	logic [STEP_W-1:0]   rev_pos;
	logic [LED_W-1:0]    base;
	mode_t               mode_inc;
	logic                do_step;

	always_comb begin
		cnt_inc = cur.ms_cnt;
		if (item.tick && (cur.ms_cnt != COUNTER_TOP)) begin
			cnt_inc = cur.ms_cnt + PERIOD_W'(1);
		end
		do_step = (cnt_inc >= period_ms);

		step_inc = cur.step + STEP_W'(1);
		hi_pos   = {1'b0, cur.step} + (STEP_W+1)'(4);
		rev_pos  = STEP_W'(7) - cur.step;
		base     = (cur.step == '0) ? LEDS_ALL_OFF : cur.leds;

		leds_stp = cur.leds;
		step_stp = step_inc;
		case (cur.mode)
			MODE_ALL_ON: begin
				leds_stp = LEDS_ALL_ON;
				step_stp = cur.step;
			end
			MODE_ALL_OFF: begin
				leds_stp = LEDS_ALL_OFF;
				step_stp = cur.step;
			end
			MODE_FLOWER_OPEN: begin
				leds_stp = base;
				// Positions that fall outside the register are dropped.
				if (!hi_pos[STEP_W]) begin
					leds_stp[hi_pos[STEP_W-1:0]] = 1'b1;
				end
				if (!cur.step[STEP_W-1]) begin
					leds_stp[3'd3 - cur.step] = 1'b1;
				end
				if (step_inc >= FLOWER_STEPS || step_inc == '0) begin
					step_stp = '0;
				end
			end
			MODE_FLOWER_CLOSE: begin
				leds_stp = cur.leds;
				leds_stp[cur.step] = 1'b0;
				leds_stp[rev_pos]  = 1'b0;
				if (step_inc >= FLOWER_STEPS || step_inc == '0) begin
					step_stp = '0;
					leds_stp = LEDS_ALL_ON;
				end
			end
			MODE_FILL_UP: begin
				leds_stp = base;
				leds_stp[cur.step] = 1'b1;
			end
			MODE_FILL_DOWN: begin
				leds_stp = base;
				leds_stp[rev_pos] = 1'b1;
			end
			MODE_DOT_UP: begin
				leds_stp = LEDS_ALL_OFF;
				leds_stp[cur.step] = 1'b1;
			end
			MODE_DOT_DOWN: begin
				leds_stp = LEDS_ALL_OFF;
				leds_stp[rev_pos] = 1'b1;
			end
			default: begin
				leds_stp = cur.leds;
				step_stp = cur.step;
			end
		endcase

		nxt.ms_cnt = cnt_inc;
		nxt.leds   = cur.leds;
		nxt.step   = cur.step;
		nxt.mode   = cur.mode;
		if (do_step) begin
			nxt.ms_cnt = '0;
			nxt.leds   = leds_stp;
			nxt.step   = step_stp;
		end

		// A press is applied after any pattern step of the same transaction.
		mode_inc = mode_t'(cur.mode + MODE_W'(1));
		if (item.press) begin
			nxt.mode = mode_inc;
			nxt.step = '0;
			if (mode_inc == MODE_FLOWER_CLOSE) begin
				nxt.leds = LEDS_ALL_ON;
			end else if (mode_inc >= MODE_FILL_UP) begin
				nxt.leds = LEDS_ALL_OFF;
			end
		end
	end

endmodule

### rtl/button_led_pattern_sequencer_core.sv
// A result passes through the input register and then the result
// register before it becomes valid.
// Throughput: one input transaction per cycle while results are accepted;
// the single next-state function of the sequencer state bounds the rate.
// Reset (arst_n low, asynchronous): LEDs off, mode all-on, step and
// millisecond counter zero, period 200, both pipeline stages empty.
module button_led_pattern_sequencer_core
	import blps_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	blps_item_if.sink     item,
	blps_result_if.source result,
	blps_cfg_if.sink      cfg
);

	logic                valid_s1;
	item_t               item_s1;
	logic                valid_s2;
	logic [LED_W-1:0]    leds_s2;
	logic [MODE_W-1:0]   mode_s2;
	logic [PERIOD_W-1:0] period_q;
	seq_state_t          state_q;
	seq_state_t          state_nxt;
	logic                adv_s1;

	assign adv_s1     = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv_s1;
	assign cfg.ready  = 1'b1;

	assign result.valid = valid_s2;
	assign result.leds  = leds_s2;
	assign result.mode  = mode_s2;

	blps_step u_step (
		.cur       (state_q),
		.item      (item_s1),
		.period_ms (period_q),
		.nxt       (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			period_q      <= PERIOD_RESET;
			state_q.leds  <= LEDS_ALL_OFF;
			state_q.mode  <= MODE_ALL_ON;
			state_q.step  <= '0;
			state_q.ms_cnt <= '0;
		end else begin
			if (cfg.valid) begin
				period_q <= cfg.period_ms;
			end
			if (item.valid && item.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.tick  <= item.tick;
			item_s1.press <= item.press;
		end
		if (adv_s1) begin
			leds_s2 <= state_nxt.leds;
			mode_s2 <= state_nxt.mode;
		end
	end

endmodule
